>>> hw/rtl/abtm_pkg.sv
// Package for the ARP binding table monitor: sizes, status codes, entry type.
// No dependencies.
`default_nettype none
package abtm_pkg;
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [7:0] OP_REQUEST = 8'h01;
  localparam logic [7:0] OP_REPLY   = 8'h02;
  localparam logic [7:0] BCAST_BYTE = 8'hff;

  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_REQUEST = 3'd1;
  localparam logic [2:0] ST_NEW     = 3'd2;
  localparam logic [2:0] ST_REFRESH = 3'd3;
  localparam logic [2:0] ST_CHANGED = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [47:0] prev_mac;
    logic [47:0] eth_source;
    logic [15:0] bcast;
    logic [15:0] ucast;
    logic [15:0] changes;
    logic        mismatch;
    logic [31:0] sec;
    logic [29:0] nsec;
    logic [31:0] prev_sec;
    logic [29:0] prev_nsec;
  } entry_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/arp_binding_table_monitor.sv
// ARP binding table monitor: 1R1W entry memory, linear search, RMW update.
// Depends on abtm_pkg.
//
// Usage: one ARP packet's fields per transfer on the in_ channel; one result
// per item on the out_ channel. A request or an ignored opcode is decoded in
// S_DEC, which registers its result. A reply scans the filled entries one
// per cycle through the entry memory (registered read) and writes back the
// hit or new entry in the cycle of the last compare, or writes nothing and
// reports ST_FULL on a miss in a full table; the scan ends at the hit or,
// on a miss, after the last filled entry. After a result transfer the block
// returns to idle and can take the next item in the following cycle. The
// scan over the single read port sets the pace for replies.
// One item is in work at a time; in_ready is high only in the idle state.
// The result sits in an output register until taken; a stalled receiver
// holds the block in the done state and no new item is taken.
// Reset (synchronous, rst_n low) empties the table by clearing the fill count;
// the memory contents need no clearing since only entries below the fill
// count are ever compared.
`default_nettype none
module arp_binding_table_monitor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_opcode,
  input  wire logic [47:0] in_eth_dest_mac,
  input  wire logic [47:0] in_eth_source_mac,
  input  wire logic [47:0] in_sender_mac,
  input  wire logic [31:0] in_sender_ip,
  input  wire logic [31:0] in_time_sec,
  input  wire logic [29:0] in_time_nsec,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic             out_unicast_request,
  output logic             out_source_mismatch,
  output logic [6:0]       out_entry_number,
  output logic [15:0]      out_bcast_replies,
  output logic [15:0]      out_ucast_replies,
  output logic [15:0]      out_change_count,
  output logic             out_stored_mismatch,
  output logic [47:0]      out_previous_mac,
  output logic [31:0]      out_previous_sec
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0] state_r, state_nxt;
  logic [abtm_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [abtm_pkg::CNT_W-1:0] addr_r, addr_nxt;   // address being read
  logic rd_pend_r, rd_pend_nxt;                   // rd_q holds valid read data
  logic [abtm_pkg::IDX_W-1:0] rd_idx_r;

  // held item
  logic [7:0]  op_r;
  logic [47:0] da_r, sa_r, smac_r;
  logic [31:0] sip_r, sec_r;
  logic [29:0] nsec_r;

  abtm_pkg::entry_t mem [abtm_pkg::TABLE_ENTRIES];
  abtm_pkg::entry_t rd_q;
  logic             we;
  logic [abtm_pkg::IDX_W-1:0] wa;
  abtm_pkg::entry_t wd;

  logic [2:0]  st_r, st_nxt;
  logic        ureq_r, ureq_nxt, smis_r, smis_nxt;
  logic [6:0]  num_r, num_nxt;
  logic [15:0] bc_r, bc_nxt, uc_r, uc_nxt, chg_r, chg_nxt;
  logic        mark_r, mark_nxt;
  logic [47:0] pmac_r, pmac_nxt;
  logic [31:0] psec_r, psec_nxt;

  logic bcast, alert;
  assign bcast = (da_r[47:40] == abtm_pkg::BCAST_BYTE);
  assign alert = (smac_r != sa_r);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[addr_r[abtm_pkg::IDX_W-1:0]];
    rd_idx_r <= addr_r[abtm_pkg::IDX_W-1:0];
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_opcode[7:0];
      da_r   <= in_eth_dest_mac;
      sa_r   <= in_eth_source_mac;
      smac_r <= in_sender_mac;
      sip_r  <= in_sender_ip;
      sec_r  <= in_time_sec;
      nsec_r <= in_time_nsec;
    end
  end

  always_comb begin
    abtm_pkg::entry_t e;
    e = rd_q;
    state_nxt = state_r;
    fill_nxt = fill_r;
    addr_nxt = addr_r;
    rd_pend_nxt = 1'b0;
    we = 1'b0;
    wa = rd_idx_r;
    wd = rd_q;
    st_nxt = st_r; ureq_nxt = ureq_r; smis_nxt = smis_r; num_nxt = num_r;
    bc_nxt = bc_r; uc_nxt = uc_r; chg_nxt = chg_r; mark_nxt = mark_r;
    pmac_nxt = pmac_r; psec_nxt = psec_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DEC;
        addr_nxt = '0;
      end
      S_DEC: begin
        st_nxt = abtm_pkg::ST_IGNORED; ureq_nxt = 1'b0; smis_nxt = 1'b0;
        num_nxt = '0; bc_nxt = '0; uc_nxt = '0; chg_nxt = '0; mark_nxt = 1'b0;
        pmac_nxt = '0; psec_nxt = '0;
        if (op_r == abtm_pkg::OP_REQUEST) begin
          st_nxt = abtm_pkg::ST_REQUEST;
          ureq_nxt = ~da_r[40];
          state_nxt = S_DONE;
        end else if (op_r == abtm_pkg::OP_REPLY) begin
          smis_nxt = alert;
          state_nxt = S_SCAN;
          if (fill_r != '0) begin
            rd_pend_nxt = 1'b1;
            addr_nxt = addr_r + 1'b1;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (rd_pend_r && rd_q.ip == sip_r) begin
          // hit: update in place
          if (bcast) e.bcast = abtm_pkg::sat_inc(rd_q.bcast);
          else       e.ucast = abtm_pkg::sat_inc(rd_q.ucast);
          e.sec = sec_r;
          e.nsec = nsec_r;
          if (rd_q.mac == smac_r) begin
            st_nxt = abtm_pkg::ST_REFRESH;
          end else begin
            e.changes   = abtm_pkg::sat_inc(rd_q.changes);
            e.prev_mac  = rd_q.mac;
            e.mac       = smac_r;
            e.prev_sec  = rd_q.sec;
            e.prev_nsec = rd_q.nsec;
            if (alert) e.mismatch = 1'b1;
            st_nxt = abtm_pkg::ST_CHANGED;
          end
          we = 1'b1; wa = rd_idx_r; wd = e;
          num_nxt = 7'({1'b0, rd_idx_r} + 1);
          bc_nxt = e.bcast; uc_nxt = e.ucast; chg_nxt = e.changes;
          mark_nxt = e.mismatch; pmac_nxt = e.prev_mac; psec_nxt = e.prev_sec;
          state_nxt = S_DONE;
        end else if (rd_pend_r && addr_r < fill_r) begin
          rd_pend_nxt = 1'b1;
          addr_nxt = addr_r + 1'b1;
        end else if (fill_r == abtm_pkg::CNT_W'(abtm_pkg::TABLE_ENTRIES)) begin
          st_nxt = abtm_pkg::ST_FULL;
          state_nxt = S_DONE;
        end else begin
          e.ip = sip_r; e.mac = smac_r; e.prev_mac = '0; e.eth_source = sa_r;
          e.bcast = {15'd0, bcast}; e.ucast = {15'd0, ~bcast}; e.changes = 16'd1;
          e.mismatch = alert; e.sec = sec_r; e.nsec = nsec_r;
          e.prev_sec = '0; e.prev_nsec = '0;
          we = 1'b1; wa = fill_r[abtm_pkg::IDX_W-1:0]; wd = e;
          fill_nxt = fill_r + 1'b1;
          st_nxt = abtm_pkg::ST_NEW;
          num_nxt = 7'(fill_r + 1'b1);
          bc_nxt = e.bcast; uc_nxt = e.ucast; chg_nxt = 16'd1; mark_nxt = alert;
          pmac_nxt = '0; psec_nxt = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      addr_r <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      addr_r <= addr_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt; ureq_r <= ureq_nxt; smis_r <= smis_nxt; num_r <= num_nxt;
    bc_r <= bc_nxt; uc_r <= uc_nxt; chg_r <= chg_nxt; mark_r <= mark_nxt;
    pmac_r <= pmac_nxt; psec_r <= psec_nxt;
  end

  assign out_status = st_r;
  assign out_unicast_request = ureq_r;
  assign out_source_mismatch = smis_r;
  assign out_entry_number = num_r;
  assign out_bcast_replies = bc_r;
  assign out_ucast_replies = uc_r;
  assign out_change_count = chg_r;
  assign out_stored_mismatch = mark_r;
  assign out_previous_mac = pmac_r;
  assign out_previous_sec = psec_r;
endmodule
`default_nettype wire

>>> hw/rtl/abtm_checker.sv
// Port-level checker for the ARP binding table monitor, bound to the top.
// Depends on abtm_pkg.
`default_nettype none
module abtm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic       out_unicast_request,
  input wire logic       out_source_mismatch,
  input wire logic [6:0] out_entry_number
);
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");
  a_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == abtm_pkg::ST_IGNORED ||
      out_status == abtm_pkg::ST_REQUEST || out_status == abtm_pkg::ST_FULL)
    |-> out_entry_number == 7'd0) else $error("entry number without entry");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_unicast_request && out_source_mismatch))
    else $error("request and reply flags together");
endmodule

bind arp_binding_table_monitor abtm_checker u_abtm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_unicast_request(out_unicast_request),
  .out_source_mismatch(out_source_mismatch),
  .out_entry_number(out_entry_number)
);
`default_nettype wire

>>> dv/testbench.sv
// Testbench for the ARP binding table monitor: directed and random ARP traffic
// checked against an in-bench model of the binding table. Depends on abtm_pkg.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic        unicast_request;
    logic        source_mismatch;
    logic [6:0]  entry_number;
    logic [15:0] bcast;
    logic [15:0] ucast;
    logic [15:0] changes;
    logic        mark;
    logic [47:0] prev_mac;
    logic [31:0] prev_sec;
  } arp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_opcode = '0;
  logic [47:0] in_eth_dest_mac = '0;
  logic [47:0] in_eth_source_mac = '0;
  logic [47:0] in_sender_mac = '0;
  logic [31:0] in_sender_ip = '0;
  logic [31:0] in_time_sec = '0;
  logic [29:0] in_time_nsec = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic out_unicast_request, out_source_mismatch, out_stored_mismatch;
  logic [6:0] out_entry_number;
  logic [15:0] out_bcast_replies, out_ucast_replies, out_change_count;
  logic [47:0] out_previous_mac;
  logic [31:0] out_previous_sec;

  arp_binding_table_monitor u_top (.*);

  // binding table model
  abtm_pkg::entry_t bindings[abtm_pkg::TABLE_ENTRIES];
  int          bound_count = 0;
  arp_result_t pending_results[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          error_count = 0;
  int          idle_cycles = 0;
  logic [31:0] known_ips[$];
  logic [47:0] known_macs[$];

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] count_up(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic arp_result_t predict_arp(input logic [15:0] op, input logic [47:0] da,
      input logic [47:0] sa, input logic [47:0] smac, input logic [31:0] sip,
      input logic [31:0] sec, input logic [29:0] nsec);
    arp_result_t r;
    int hit;
    logic is_bcast;
    r = '0;
    hit = -1;
    is_bcast = (da[47:40] == abtm_pkg::BCAST_BYTE);
    if (op[7:0] == abtm_pkg::OP_REQUEST) begin
      r.status = abtm_pkg::ST_REQUEST;
      r.unicast_request = ~da[40];
      return r;
    end
    if (op[7:0] != abtm_pkg::OP_REPLY) begin
      r.status = abtm_pkg::ST_IGNORED;
      return r;
    end
    r.source_mismatch = (smac != sa);
    for (int k = 0; k < bound_count; k++) begin
      if (hit < 0 && bindings[k].ip == sip) hit = k;
    end
    if (hit < 0) begin
      if (bound_count >= abtm_pkg::TABLE_ENTRIES) begin
        r.status = abtm_pkg::ST_FULL;
        return r;
      end
      hit = bound_count;
      bindings[hit] = '0;
      bindings[hit].ip = sip;
      bindings[hit].mac = smac;
      bindings[hit].eth_source = sa;
      bindings[hit].bcast = is_bcast ? 16'd1 : 16'd0;
      bindings[hit].ucast = is_bcast ? 16'd0 : 16'd1;
      bindings[hit].changes = 16'd1;
      bindings[hit].mismatch = r.source_mismatch;
      bindings[hit].sec = sec;
      bindings[hit].nsec = nsec;
      bound_count++;
      r.status = abtm_pkg::ST_NEW;
    end else begin
      if (is_bcast) bindings[hit].bcast = count_up(bindings[hit].bcast);
      else bindings[hit].ucast = count_up(bindings[hit].ucast);
      if (bindings[hit].mac == smac) begin
        r.status = abtm_pkg::ST_REFRESH;
      end else begin
        bindings[hit].changes = count_up(bindings[hit].changes);
        bindings[hit].prev_mac = bindings[hit].mac;
        bindings[hit].mac = smac;
        bindings[hit].prev_sec = bindings[hit].sec;
        bindings[hit].prev_nsec = bindings[hit].nsec;
        if (r.source_mismatch) bindings[hit].mismatch = 1'b1;
        r.status = abtm_pkg::ST_CHANGED;
      end
      bindings[hit].sec = sec;
      bindings[hit].nsec = nsec;
    end
    r.entry_number = 7'(hit + 1);
    r.bcast = bindings[hit].bcast;
    r.ucast = bindings[hit].ucast;
    r.changes = bindings[hit].changes;
    r.mark = bindings[hit].mismatch;
    r.prev_mac = bindings[hit].prev_mac;
    r.prev_sec = bindings[hit].prev_sec;
    return r;
  endfunction

  // valid stays up after a transfer unless the sender idles; the next call
  // either drops it or puts the next payload on the same edge
  task automatic send_packet(input logic [15:0] op, input logic [47:0] da,
      input logic [47:0] sa, input logic [47:0] smac, input logic [31:0] sip,
      input logic [31:0] sec, input logic [29:0] nsec);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_eth_dest_mac <= da;
    in_eth_source_mac <= sa;
    in_sender_mac <= smac;
    in_sender_ip <= sip;
    in_time_sec <= sec;
    in_time_nsec <= nsec;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_arp(op, da, sa, smac, sip, sec, nsec));
  endtask

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // reply from a known or fresh sender, random mismatch and broadcast
  task automatic send_reply_traffic();
    logic [31:0] sip;
    logic [47:0] smac, da;
    if (known_ips.size() > 0 && $urandom_range(99) < 75) begin
      sip = known_ips[$urandom_range(known_ips.size() - 1)];
    end else begin
      sip = $urandom;
      known_ips.push_back(sip);
    end
    smac = ($urandom_range(2) == 0 || known_macs.size() == 0) ? rand_mac()
         : known_macs[$urandom_range(known_macs.size() - 1)];
    if (known_macs.size() < 6) known_macs.push_back(smac);
    da = $urandom_range(1) ? 48'hffff_ffff_ffff : rand_mac();
    send_packet({8'($urandom), abtm_pkg::OP_REPLY}, da,
                ($urandom_range(3) == 0) ? rand_mac() : smac,
                smac, sip, $urandom, 30'($urandom));
  endtask

  task automatic send_random_packet();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) send_reply_traffic();
    else if (pick < 85)
      send_packet({8'($urandom), abtm_pkg::OP_REQUEST}, rand_mac(), rand_mac(),
                  rand_mac(), $urandom, $urandom, 30'($urandom));
    else
      send_packet(16'($urandom), rand_mac(), rand_mac(), rand_mac(), $urandom,
                  $urandom, 30'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (abtm_pkg::TABLE_ENTRIES + 8) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [47:0] m1, m2;
    m1 = 48'h0011_2233_4455;
    m2 = 48'hffee_ddcc_bbaa;
    send_packet({8'h00, abtm_pkg::OP_REQUEST}, 48'hffff_ffff_ffff, m1, m1, 32'h0,
                32'd0, 30'd0);
    send_packet({8'hff, abtm_pkg::OP_REQUEST}, 48'h0000_0000_0000, m1, m1, '1, '1, '1);
    send_packet({8'h5a, abtm_pkg::OP_REQUEST}, 48'h0100_0000_0000, m2, m2, 32'd1,
                32'd2, 30'd3);
    send_packet(16'h0000, m1, m1, m1, 32'd1, 32'd1, 30'd1);
    send_packet(16'hffff, m2, m2, m2, 32'd1, 32'd1, 30'd1);
    send_packet(16'h0103, m2, m2, m2, 32'd1, 32'd1, 30'd1);
    // new, refresh, change, change back with mismatch
    send_packet({8'h00, abtm_pkg::OP_REPLY}, 48'hffff_ffff_ffff, m1, m1, 32'h0,
                32'd5, 30'd7);
    send_packet({8'hff, abtm_pkg::OP_REPLY}, m2, m1, m1, 32'h0, '1, 30'h3fff_ffff);
    send_packet({8'h00, abtm_pkg::OP_REPLY}, 48'hff00_0000_0000, m2, m2, 32'h0,
                32'd9, 30'd1);
    send_packet({8'h00, abtm_pkg::OP_REPLY}, 48'h0, m2, m1, 32'h0, 32'd11, 30'd2);
    send_packet({8'h00, abtm_pkg::OP_REPLY}, 48'h0, m2, m2, '1, '0, 30'd999_999_999);
    send_packet({8'h00, abtm_pkg::OP_REPLY}, 48'h0, '0, '1, 32'h8000_0001, 32'd1,
                30'd1);
    known_ips.push_back(32'h0);
    known_ips.push_back('1);
    known_macs.push_back(m1);
    known_macs.push_back(m2);
  endtask

  task automatic test_repeated_hits();
    // one entry hit over and over, its unicast count rising; its MAC changes once
    repeat (40) send_packet({8'h00, abtm_pkg::OP_REPLY}, 48'h0, 48'h1, 48'h1, 32'h0,
                            32'd0, 30'd0);
  endtask

  task automatic test_random(input int items, input int s_idle, input int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (items) send_random_packet();
  endtask

  task automatic test_table_full();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (bound_count < abtm_pkg::TABLE_ENTRIES) send_reply_traffic();
    repeat (10) send_packet({8'h00, abtm_pkg::OP_REPLY}, 48'h0, 48'h2, 48'h2, $urandom,
                            32'd0, 30'd0);
    repeat (60) send_reply_traffic();
  endtask

  // result checker
  always @(posedge clk) begin
    arp_result_t got, want;
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (in_valid && in_ready) idle_cycles <= 0;
      else if (out_valid && out_ready) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        got = {out_status, out_unicast_request, out_source_mismatch, out_entry_number,
               out_bcast_replies, out_ucast_replies, out_change_count,
               out_stored_mismatch, out_previous_mac, out_previous_sec};
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); error_count++;
          end
          if (got.unicast_request !== want.unicast_request) begin
            $error("unicast_request exp %0d got %0d", want.unicast_request,
                   got.unicast_request); error_count++;
          end
          if (got.source_mismatch !== want.source_mismatch) begin
            $error("source_mismatch exp %0d got %0d", want.source_mismatch,
                   got.source_mismatch); error_count++;
          end
          if (got.entry_number !== want.entry_number) begin
            $error("entry_number exp %0d got %0d", want.entry_number, got.entry_number);
            error_count++;
          end
          if (got.bcast !== want.bcast) begin
            $error("bcast_replies exp %0d got %0d", want.bcast, got.bcast); error_count++;
          end
          if (got.ucast !== want.ucast) begin
            $error("ucast_replies exp %0d got %0d", want.ucast, got.ucast); error_count++;
          end
          if (got.changes !== want.changes) begin
            $error("change_count exp %0d got %0d", want.changes, got.changes);
            error_count++;
          end
          if (got.mark !== want.mark) begin
            $error("stored_mismatch exp %0d got %0d", want.mark, got.mark); error_count++;
          end
          if (got.prev_mac !== want.prev_mac) begin
            $error("previous_mac exp %h got %h", want.prev_mac, got.prev_mac);
            error_count++;
          end
          if (got.prev_sec !== want.prev_sec) begin
            $error("previous_sec exp %h got %h", want.prev_sec, got.prev_sec);
            error_count++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_repeated_hits();
    test_random(200, 11, 74);
    wait_drained();  // sender holds off until the table has answered everything
    test_random(250, 74, 11);
    test_table_full();
    test_random(100, 0, 0);
    wait_drained();
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
